FILE: design/lil_pkg.sv
// Shared types and constants for the indexed list engine.
package lil_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ITEM_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int EXT_W          = 64;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_POP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
  } lil_op_t;

endpackage

FILE: design/lil_cells.sv
// Row of list cells with the fill count; all cells shift in parallel for insert and delete.
module lil_cells #(
  parameter int CAPACITY   = lil_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH = lil_pkg::ITEM_WIDTH_DEF,
  parameter int POS_W      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lil_pkg::lil_op_t      op,
  input  logic [POS_W-1:0]      idx,
  input  logic [ITEM_WIDTH-1:0] item,
  output logic [ITEM_WIDTH-1:0] rd,
  output logic [POS_W-1:0]      fill,
  output logic [POS_W-1:0]      fill_next
);
  import lil_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic [ITEM_WIDTH-1:0] slots [CAPACITY];

  assign rd = slots[idx[AW-1:0]];

  always_comb begin
    fill_next = fill;
    if (op.ins) begin
      fill_next = fill + POS_W'(1);
    end else if (op.del) begin
      fill_next = fill - POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (op.ins) begin
        if (POS_W'(i) == idx) begin
          slots[i] <= item;
        end else if (POS_W'(i) > idx && i > 0) begin
          slots[i] <= slots[(i > 0) ? i - 1 : 0];
        end
      end else if (op.del) begin
        if (POS_W'(i) >= idx && i + 1 < CAPACITY) begin
          slots[i] <= slots[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

endmodule

FILE: design/indexed_list_engine_top.sv
// Top level of the indexed list engine: input register, request decode, result register.
// An accepted request waits in the input register until the output can advance; then its result is registered.
// Throughput: one request per cycle while out_stall does not hold the output; the list cells shift in parallel.
// The next request sees the list as the previous one left it, with no bubble.
// Reset: rst (synchronous) empties the list and clears both valid flags.
// Cell contents are not cleared; only cells below the count are ever read.
module indexed_list_engine_top #(
  parameter int CAPACITY   = lil_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH = lil_pkg::ITEM_WIDTH_DEF,
  parameter int POS_W      = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic [POS_W-1:0]                   position,
  input  logic                               at_back,
  input  logic signed [lil_pkg::VALUE_W-1:0] new_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lil_pkg::VALUE_W-1:0] value,
  output logic [1:0]                         status,
  output logic [POS_W-1:0]                   count,
  output logic                               is_empty
);
  import lil_pkg::*;

  logic                  s_valid;
  action_t               s_action;
  logic [POS_W-1:0]      s_position;
  logic                  s_at_back;
  logic [VALUE_W-1:0]    s_item;

  logic                  adv;
  logic                  take;
  lil_op_t               op;
  logic [POS_W-1:0]      idx;
  logic [ITEM_WIDTH-1:0] item;
  logic [ITEM_WIDTH-1:0] rd;
  logic [POS_W-1:0]      fill;
  logic [POS_W-1:0]      fill_next;
  status_t               st;
  logic                  rd_ok;
  logic signed [EXT_W-1:0] item_ext;
  logic signed [EXT_W-1:0] rd_ext;
  logic [VALUE_W-1:0]    value_next;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = s_valid && !adv;
  assign take     = s_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_action   <= action_t'(action);
      s_position <= position;
      s_at_back  <= at_back;
      s_item     <= new_item;
    end
  end

  assign item_ext = EXT_W'(signed'(s_item));
  assign item     = item_ext[ITEM_WIDTH-1:0];
  assign rd_ext   = EXT_W'(signed'(rd));

  always_comb begin
    st    = ST_OK;
    rd_ok = 1'b0;
    op    = '0;
    unique case (s_action)
      ACT_INSERT: begin
        idx = s_at_back ? fill : s_position;
        if (idx > fill) begin
          st = ST_RANGE;
        end else if (fill >= POS_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          op.ins = take;
        end
      end
      ACT_READ, ACT_DELETE, ACT_POP: begin
        if (s_at_back) begin
          idx = (fill != '0) ? fill - POS_W'(1) : '0;
        end else begin
          idx = s_position;
        end
        if (fill == '0 || idx >= fill) begin
          st = ST_RANGE;
        end else begin
          rd_ok  = (s_action == ACT_READ) || (s_action == ACT_POP);
          op.del = take && ((s_action == ACT_DELETE) || (s_action == ACT_POP));
        end
      end
      default: begin
        idx = s_position;
      end
    endcase
    value_next = rd_ok ? rd_ext[VALUE_W-1:0] : '1;
  end

  lil_cells #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH),
    .POS_W      (POS_W)
  ) u_cells (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .idx       (idx),
    .item      (item),
    .rd        (rd),
    .fill      (fill),
    .fill_next (fill_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value    <= value_next;
      status   <= st;
      count    <= fill_next;
      is_empty <= (fill_next == '0);
    end
  end

endmodule

FILE: bench/indexed_list_engine_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the indexed list engine with a queue-based list predictor.
module indexed_list_engine_top_test;
  import lil_pkg::*;

  localparam int LIST_CAP      = CAPACITY_DEF;
  localparam int POS_W         = $clog2(LIST_CAP + 1);
  localparam int POS_MAX       = (1 << POS_W) - 1;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int CALM_ITEMS    = 200;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    action_t                   act;
    logic [POS_W-1:0]          pos;
    logic                      back;
    logic signed [VALUE_W-1:0] item;
    logic                      drain;
    logic                      calm;
  } list_request_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic [POS_W-1:0]          count;
    logic                      is_empty;
  } list_result_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [1:0]                action    = ACT_READ;
  logic [POS_W-1:0]          position  = '0;
  logic                      at_back   = 1'b0;
  logic signed [VALUE_W-1:0] new_item  = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic [1:0]                status;
  logic [POS_W-1:0]          count;
  logic                      is_empty;

  list_request_t             pending_reqs[$];
  list_result_t              expected_results[$];
  logic signed [VALUE_W-1:0] held_items[$];
  int unsigned               error_count  = 0;
  int unsigned               quiet_cycles = 0;
  int                        idle_left    = 0;
  int                        stall_left   = 0;
  logic                      calm_phase   = 1'b0;
  int unsigned               gen_fill     = 0;
  logic                      gen_drain    = 1'b0;
  logic                      gen_calm     = 1'b0;

  indexed_list_engine_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .position  (position),
    .at_back   (at_back),
    .new_item  (new_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic list_result_t apply_request(action_t act, logic [POS_W-1:0] pos,
                                                 logic back, logic signed [VALUE_W-1:0] item);
    list_result_t r;
    int unsigned  n;
    int unsigned  idx;
    n = held_items.size();
    r.value  = -1;
    r.status = ST_OK;
    if (act == ACT_INSERT) begin
      idx = back ? n : pos;
      if (idx > n) r.status = ST_RANGE;
      else if (n >= LIST_CAP) r.status = ST_FULL;
      else held_items.insert(idx, item);
    end else begin
      idx = back ? ((n != 0) ? n - 1 : 0) : pos;
      if (n == 0 || idx >= n) begin
        r.status = ST_RANGE;
      end else begin
        if (act == ACT_READ || act == ACT_POP) r.value = held_items[idx];
        if (act == ACT_DELETE || act == ACT_POP) held_items.delete(idx);
      end
    end
    r.count    = POS_W'(held_items.size());
    r.is_empty = (held_items.size() == 0);
    return r;
  endfunction

  task automatic queue_request(action_t act, int unsigned pos, logic back,
                               logic signed [VALUE_W-1:0] item);
    list_request_t req;
    int unsigned   idx;
    req.act   = act;
    req.pos   = pos[POS_W-1:0];
    req.back  = back;
    req.item  = item;
    req.drain = gen_drain;
    req.calm  = gen_calm;
    pending_reqs.push_back(req);
    if (act == ACT_INSERT) begin
      idx = back ? gen_fill : pos;
      if (idx <= gen_fill && gen_fill < LIST_CAP) gen_fill++;
    end else if (act != ACT_READ && gen_fill != 0) begin
      idx = back ? gen_fill - 1 : pos;
      if (idx < gen_fill) gen_fill--;
    end
  endtask

  always @(posedge clk) begin : req_driver
    list_request_t nxt;
    logic          took;
    if (rst) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else begin
      took = in_valid && !in_stall;
      if (took)
        expected_results.push_back(apply_request(action_t'(action), position, at_back, new_item));
      if (!in_valid || took) begin
        if (idle_left > 0) begin
          in_valid  <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          action     <= nxt.act;
          position   <= nxt.pos;
          at_back    <= nxt.back;
          new_item   <= nxt.item;
          in_valid   <= 1'b1;
          calm_phase <= nxt.calm;
          if (!nxt.calm && $urandom_range(5, 0) == 0) idle_left <= $urandom_range(3, 1);
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    list_result_t exp_r;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected beat value=%0d status=%0d count=%0d empty=%0b",
                                 value, status, count, is_empty));
        end else begin
          exp_r = expected_results.pop_front();
          if (value !== exp_r.value || status !== exp_r.status ||
              count !== exp_r.count || is_empty !== exp_r.is_empty)
            report_error($sformatf({"expected value=%0d status=%0d count=%0d empty=%0b, ",
                                    "got value=%0d status=%0d count=%0d empty=%0b"},
                                   exp_r.value, exp_r.status, exp_r.count, exp_r.is_empty,
                                   value, status, count, is_empty));
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm_phase && $urandom_range(5, 0) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(2, 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned               n;
    int unsigned               phase_left;
    int unsigned               ins_pct;
    int unsigned               pos;
    action_t                   act;
    logic                      back;
    logic signed [VALUE_W-1:0] item;

    queue_request(ACT_READ, 0, 1'b0, 0);
    queue_request(ACT_POP, 0, 1'b1, 0);
    queue_request(ACT_DELETE, 0, 1'b0, 0);
    queue_request(ACT_INSERT, 1, 1'b0, 5);
    queue_request(ACT_INSERT, 0, 1'b0, 32'h8000_0000);
    queue_request(ACT_INSERT, 0, 1'b1, 32'h7fff_ffff);
    queue_request(ACT_INSERT, 1, 1'b0, -1);
    while (gen_fill < LIST_CAP) queue_request(ACT_INSERT, 0, 1'b1, $urandom);
    queue_request(ACT_INSERT, LIST_CAP, 1'b0, 7);
    queue_request(ACT_INSERT, LIST_CAP + 1, 1'b0, 7);
    queue_request(ACT_READ, POS_MAX, 1'b0, 0);
    queue_request(ACT_READ, 0, 1'b1, 0);
    queue_request(ACT_POP, 1, 1'b0, 0);
    queue_request(ACT_DELETE, LIST_CAP - 1, 1'b0, 0);
    queue_request(ACT_DELETE, 0, 1'b1, 0);

    phase_left = 0;
    ins_pct    = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(150, 40);
        ins_pct    = $urandom_range(85, 15);
      end
      phase_left--;
      gen_drain = (n == 0 || n == RANDOM_ITEMS / 2);
      gen_calm  = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if ($urandom_range(99, 0) < ins_pct) begin
        act = ACT_INSERT;
      end else begin
        case ($urandom_range(2, 0))
          0:       act = ACT_READ;
          1:       act = ACT_DELETE;
          default: act = ACT_POP;
        endcase
      end
      back = ($urandom_range(4, 0) == 0);
      if ($urandom_range(9, 0) == 0) pos = $urandom_range(POS_MAX, 0);
      else if (act == ACT_INSERT) pos = $urandom_range(gen_fill, 0);
      else pos = (gen_fill == 0) ? 0 : $urandom_range(gen_fill - 1, 0);
      case ($urandom_range(15, 0))
        0:       item = 32'h8000_0000;
        1:       item = 32'h7fff_ffff;
        2:       item = -1;
        3:       item = 0;
        default: item = $urandom;
      endcase
      queue_request(act, pos, back, item);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lil_pkg.sv
design/lil_cells.sv
design/indexed_list_engine_top.sv
bench/indexed_list_engine_top_test.sv
